// ===== rtl/pid_position_controller_macros.svh =====
// ----------------------------------------------------------------------------
// pid_position_controller_macros
// assertion macros shared by the position controller rtl
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_CONTROLLER_MACROS_SVH
`define PID_POSITION_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PIDPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidpc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PIDPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidpc assertion failed");

`endif

// ===== rtl/pidpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidpc_pkg
// shared widths, register indexes, reset values and types of the position
// controller
// ----------------------------------------------------------------------------
package pidpc_pkg;

  // field widths
  localparam int unsigned AngleW  = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned PowerW  = 8;
  localparam int unsigned MaxPwrW = 7;
  localparam int unsigned TolW    = 16;
  localparam int unsigned LimitW  = 15;
  localparam int unsigned ErrW    = AngleW + 1;   // measured minus target
  localparam int unsigned IntegW  = 16;           // clamped accumulated error
  localparam int unsigned DerivW  = ErrW + 1;     // error minus last error

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegKpGain   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKiGain   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKdGain   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxPower = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTol      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIntegLim = 3'd5;

  // register reset values
  localparam logic [GainW-1:0]   KpReset     = 16'd3277;
  localparam logic [GainW-1:0]   KiReset     = 16'd66;
  localparam logic [GainW-1:0]   KdReset     = 16'd328;
  localparam logic [MaxPwrW-1:0] MaxPwrReset = 7'd90;
  localparam logic [TolW-1:0]    TolReset    = 16'd5;
  localparam logic [LimitW-1:0]  LimitReset  = 15'd5000;

  // terms of one control tick, handed from the state unit to the datapath
  typedef struct packed {
    logic signed [ErrW-1:0]   err;
    logic signed [IntegW-1:0] integ;
    logic signed [DerivW-1:0] deriv;
    logic                     done;
  } terms_t;

endpackage

// ===== rtl/pid_position_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_controller
// pid position loop for one rotary axis with integral clamp, power clamp and
// finish detection; one control tick in, one drive command out
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit first)                 tuser
//  s_axis    in         measured_angle[15:0] target[15:0]     new_move
//  m_axis    out        drive_power[7:0] (signed)             done_res
//  cfg       in         write enable, index 0..5, 16 bit data  -
//
//  one tick accepted per cycle while the output does not stall; a tick passes
//  through the input, terms, products and result registers in turn
//  the loop state is updated as a tick leaves the input register, so the next
//  tick already sees it
//  each register stage advances when its successor is empty or advancing;
//  a stalled output holds the pipeline back stage by stage
//  reset loads the register defaults and clears the loop state
// ----------------------------------------------------------------------------
`include "pid_position_controller_macros.svh"

module pid_position_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input ticks
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [2*pidpc_pkg::AngleW-1:0]    s_axis_tdata,  // measured_angle, target_angle
  input  logic                              s_axis_tuser,  // new_move
  // drive commands
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pidpc_pkg::PowerW-1:0]      m_axis_tdata,  // drive_power
  output logic                              m_axis_tuser,  // done_res
  // configuration
  input  logic                              cfg_we_i,
  input  logic [pidpc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pidpc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import pidpc_pkg::*;

  localparam int unsigned ProdPW = GainW + 1 + ErrW;
  localparam int unsigned ProdIW = GainW + 1 + IntegW;
  localparam int unsigned ProdDW = GainW + 1 + DerivW;
  localparam int unsigned SumW   = ProdDW + 2;
  localparam int unsigned PwrW   = SumW - 16;

  // configuration registers
  logic [GainW-1:0]   kp_q, ki_q, kd_q;
  logic [MaxPwrW-1:0] max_pwr_q;
  logic [TolW-1:0]    tol_q;
  logic [LimitW-1:0]  limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= KpReset;
      ki_q      <= KiReset;
      kd_q      <= KdReset;
      max_pwr_q <= MaxPwrReset;
      tol_q     <= TolReset;
      limit_q   <= LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegKpGain:   kp_q      <= cfg_data_i;
        RegKiGain:   ki_q      <= cfg_data_i;
        RegKdGain:   kd_q      <= cfg_data_i;
        RegMaxPower: max_pwr_q <= cfg_data_i[MaxPwrW-1:0];
        RegTol:      tol_q     <= cfg_data_i;
        RegIntegLim: limit_q   <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and load enables
  logic v0_q, v1_q, v2_q, v3_q;
  logic ld0, ld1, ld2, ld3;

  assign ld3 = !v3_q || m_axis_tready;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign ld0 = !v0_q || ld1;

  assign s_axis_tready = ld0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld0) v0_q <= s_axis_tvalid;
      if (ld1) v1_q <= v0_q;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
    end
  end

  // input register
  logic [AngleW-1:0] meas_q, targ_q;
  logic              nm_q;

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      meas_q <= s_axis_tdata[AngleW-1:0];
      targ_q <= s_axis_tdata[2*AngleW-1:AngleW];
      nm_q   <= s_axis_tuser;
    end
  end

  // loop state and terms
  terms_t terms, terms_q;

  pidpc_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (v0_q && ld1),
    .meas_i     (meas_q),
    .targ_i     (targ_q),
    .new_move_i (nm_q),
    .tol_i      (tol_q),
    .limit_i    (limit_q),
    .terms_o    (terms)
  );

  always_ff @(posedge clk_i) begin
    if (ld1) terms_q <= terms;
  end

  // weighted terms
  logic signed [ProdPW-1:0] prod_p_q;
  logic signed [ProdIW-1:0] prod_i_q;
  logic signed [ProdDW-1:0] prod_d_q;
  logic                     done2_q;

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      prod_p_q <= $signed({1'b0, kp_q}) * terms_q.err;
      prod_i_q <= $signed({1'b0, ki_q}) * terms_q.integ;
      prod_d_q <= $signed({1'b0, kd_q}) * terms_q.deriv;
      done2_q  <= terms_q.done;
    end
  end

  // sum, truncate toward zero, clamp
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] sum_adj;
  logic signed [PwrW-1:0] pwr;
  logic signed [PwrW-1:0] mp;
  logic signed [PowerW-1:0] pwr_sat;

  assign sum = SumW'(prod_p_q) + SumW'(prod_i_q) + SumW'(prod_d_q);
  assign sum_adj = sum + (sum[SumW-1] ? SumW'(16'hFFFF) : SumW'(0));
  assign pwr = sum_adj[SumW-1:16];
  assign mp  = $signed({{(PwrW-MaxPwrW){1'b0}}, max_pwr_q});

  always_comb begin
    if (pwr > mp) begin
      pwr_sat = mp[PowerW-1:0];
    end else if (pwr < -mp) begin
      pwr_sat = PowerW'(-mp);
    end else begin
      pwr_sat = pwr[PowerW-1:0];
    end
  end

  // result register
  logic [PowerW-1:0] drive_q;
  logic              done3_q;

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      drive_q <= done2_q ? '0 : pwr_sat;
      done3_q <= done2_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = drive_q;
  assign m_axis_tuser  = done3_q;

  // a finished tick always drives zero power
  `PIDPC_ASSERT_IMPLY(a_done_zero, clk_i, rst_ni, v3_q && done3_q, drive_q == '0)
  // a waiting result is neither lost nor altered
  `PIDPC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, v3_q && !m_axis_tready, v3_q && $stable(drive_q) && $stable(done3_q))
  // an empty input register always takes a transaction
  `PIDPC_ASSERT_IMPLY(a_in_free, clk_i, rst_ni, !v0_q, s_axis_tready)

endmodule

// ===== rtl/pidpc_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidpc_state
// loop state (integral, last error, finished mark) and the error, integral
// and derivative terms of one tick
// ----------------------------------------------------------------------------
`include "pid_position_controller_macros.svh"

module pidpc_state (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           upd_i,        // tick leaves the input register
  input  logic [pidpc_pkg::AngleW-1:0]   meas_i,
  input  logic [pidpc_pkg::AngleW-1:0]   targ_i,
  input  logic                           new_move_i,
  input  logic [pidpc_pkg::TolW-1:0]     tol_i,
  input  logic [pidpc_pkg::LimitW-1:0]   limit_i,
  output pidpc_pkg::terms_t              terms_o
);
  import pidpc_pkg::*;

  logic signed [IntegW-1:0] error_sum_q, error_sum_d;
  logic signed [ErrW-1:0]   prev_err_q, prev_err_d;
  logic                     fin_q, fin_d;

  logic signed [IntegW-1:0] sum_eff;
  logic signed [ErrW-1:0]   prev_eff;
  logic                     fin_eff;
  logic signed [ErrW-1:0]   err;
  logic signed [ErrW:0]     acc;
  logic signed [ErrW:0]     lim;
  logic signed [IntegW-1:0] integ;
  logic signed [DerivW-1:0] deriv;
  logic [AngleW-1:0]        mag;
  logic                     within_tol;

  // a new move clears the state before the tick is worked
  assign sum_eff  = new_move_i ? '0 : error_sum_q;
  assign prev_eff = new_move_i ? '0 : prev_err_q;
  assign fin_eff  = fin_q && !new_move_i;

  // error and clamped integral
  assign err = $signed({1'b0, meas_i}) - $signed({1'b0, targ_i});
  assign acc = {{(ErrW+1-IntegW){sum_eff[IntegW-1]}}, sum_eff}
             + {err[ErrW-1], err};
  assign lim = $signed({{(ErrW+1-LimitW){1'b0}}, limit_i});

  always_comb begin
    if (acc > lim) begin
      integ = lim[IntegW-1:0];
    end else if (acc < -lim) begin
      integ = IntegW'(-lim);
    end else begin
      integ = acc[IntegW-1:0];
    end
  end

  // derivative and finish test
  assign deriv      = {err[ErrW-1], err} - {prev_eff[ErrW-1], prev_eff};
  assign mag        = err[ErrW-1] ? AngleW'(-err) : err[AngleW-1:0];
  assign within_tol = (mag < tol_i);

  assign terms_o.err   = err;
  assign terms_o.integ = integ;
  assign terms_o.deriv = deriv;
  assign terms_o.done  = fin_eff || within_tol;

  // next state: a finished move leaves everything as it is
  always_comb begin
    error_sum_d = error_sum_q;
    prev_err_d  = prev_err_q;
    fin_d       = fin_q;
    if (upd_i) begin
      if (fin_eff) begin
        fin_d = 1'b1;
      end else begin
        error_sum_d = integ;
        prev_err_d  = err;
        fin_d       = within_tol;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q <= '0;
      prev_err_q  <= '0;
      fin_q       <= 1'b0;
    end else begin
      error_sum_q <= error_sum_d;
      prev_err_q  <= prev_err_d;
      fin_q       <= fin_d;
    end
  end

  // a tick on a finished move keeps the loop state
  `PIDPC_ASSERT_NEXT(a_fin_hold, clk_i, rst_ni, upd_i && fin_q && !new_move_i, $stable(error_sum_q) && $stable(prev_err_q) && fin_q)
  // a finished mark is always reported as done
  `PIDPC_ASSERT_IMPLY(a_fin_done, clk_i, rst_ni, fin_q && !new_move_i, terms_o.done)

endmodule

// ===== tb/sv/pid_position_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_checker
// watches the tick, drive command and configuration channels of the position
// controller, predicts every drive command from its own copy of the loop
// state and register settings, and compares each command field by field in
// arrival order
// ----------------------------------------------------------------------------
module pid_position_checker
  import pidpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [2*AngleW-1:0]   s_axis_tdata,   // measured_angle, target_angle
  input  logic                  s_axis_tuser,   // new_move
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [PowerW-1:0]     m_axis_tdata,   // drive_power
  input  logic                  m_axis_tuser,   // done_res
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o,
  output int unsigned           finished_o
);

  typedef struct packed {
    logic signed [PowerW-1:0] power;
    logic                     done;
  } drive_cmd_t;

  // register copies
  logic [GainW-1:0]   kp_q;
  logic [GainW-1:0]   ki_q;
  logic [GainW-1:0]   kd_q;
  logic [MaxPwrW-1:0] max_pwr_q;
  logic [TolW-1:0]    tol_q;
  logic [LimitW-1:0]  integ_lim_q;

  // loop state copies
  logic signed [IntegW-1:0] err_acc_q;
  logic signed [ErrW-1:0]   last_err_q;
  logic                     move_done_q;

  drive_cmd_t  drive_cmd_q[$];
  drive_cmd_t  oldest_cmd;
  int unsigned fails;
  int unsigned checked;
  int unsigned finished_cnt;

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one control tick: updates the loop state and gives the drive command
  function automatic drive_cmd_t advance_loop(logic [AngleW-1:0] meas,
                                              logic [AngleW-1:0] targ,
                                              logic            nm);
    longint     err;
    longint     integ;
    longint     deriv;
    longint     sum;
    longint     pwr;
    longint     mag;
    drive_cmd_t cmd;
    if (nm) begin
      err_acc_q   = '0;
      last_err_q  = '0;
      move_done_q = 1'b0;
    end
    if (move_done_q) begin
      cmd.power = '0;
      cmd.done  = 1'b1;
      return cmd;
    end
    err   = longint'(meas) - longint'(targ);
    integ = clamp_mag(longint'(err_acc_q) + err, longint'(integ_lim_q));
    deriv = err - longint'(last_err_q);
    sum   = longint'(kp_q) * err + longint'(ki_q) * integ + longint'(kd_q) * deriv;
    // divide by 2^16, truncating toward zero
    if (sum < 0) pwr = -((-sum) >>> 16);
    else pwr = sum >>> 16;
    pwr = clamp_mag(pwr, longint'(max_pwr_q));
    err_acc_q  = integ[IntegW-1:0];
    last_err_q = err[ErrW-1:0];
    mag = (err < 0) ? -err : err;
    if (mag < longint'(tol_q)) begin
      move_done_q = 1'b1;
      cmd.power   = '0;
      cmd.done    = 1'b1;
    end else begin
      cmd.power = pwr[PowerW-1:0];
      cmd.done  = 1'b0;
    end
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q         = KpReset;
      ki_q         = KiReset;
      kd_q         = KdReset;
      max_pwr_q    = MaxPwrReset;
      tol_q        = TolReset;
      integ_lim_q  = LimitReset;
      err_acc_q    = '0;
      last_err_q   = '0;
      move_done_q  = 1'b0;
      drive_cmd_q.delete();
      fails        = 0;
      checked      = 0;
      finished_cnt = 0;
    end else begin
      // compare a drive command transaction with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_cmd_q.size() == 0) begin
          $display("%0t: unexpected drive command, expected none, actual power %0d done %0b",
                   $time, $signed(m_axis_tdata), m_axis_tuser);
          fails++;
        end else begin
          oldest_cmd = drive_cmd_q.pop_front();
          checked++;
          if (oldest_cmd.done) finished_cnt++;
          if (oldest_cmd.power != $signed(m_axis_tdata)) begin
            $display("%0t: drive_power mismatch, expected %0d, actual %0d",
                     $time, oldest_cmd.power, $signed(m_axis_tdata));
            fails++;
          end
          if (oldest_cmd.done != m_axis_tuser) begin
            $display("%0t: done_res mismatch, expected %0b, actual %0b",
                     $time, oldest_cmd.done, m_axis_tuser);
            fails++;
          end
        end
      end
      // predict from an accepted tick transaction
      if (s_axis_tvalid && s_axis_tready) begin
        drive_cmd_q.push_back(advance_loop(s_axis_tdata[AngleW-1:0],
                                           s_axis_tdata[2*AngleW-1:AngleW],
                                           s_axis_tuser));
      end
      // register writes, indexes beyond the list are ignored
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegKpGain:   kp_q        = cfg_data_i[GainW-1:0];
          RegKiGain:   ki_q        = cfg_data_i[GainW-1:0];
          RegKdGain:   kd_q        = cfg_data_i[GainW-1:0];
          RegMaxPower: max_pwr_q   = cfg_data_i[MaxPwrW-1:0];
          RegTol:      tol_q       = cfg_data_i[TolW-1:0];
          RegIntegLim: integ_lim_q = cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= drive_cmd_q.size();
    checked_o    <= checked;
    finished_o   <= finished_cnt;
  end

endmodule

// ===== tb/sv/tb_pid_position_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_position_controller
// drives control ticks and register settings into the position controller
// under random source and sink stalls; a directed opening hits the angle
// extremes, finishing and zero tolerance, then random moves converging on a
// target mixed with noise run under several gain settings
// ----------------------------------------------------------------------------
module tb_pid_position_controller;
  import pidpc_pkg::*;

  localparam int unsigned Latency    = 3;
  localparam int unsigned StallLimit = 400;
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned PhaseTicks = 178;

  // indexes past the register list
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [2*AngleW-1:0]   s_axis_tdata;   // measured_angle, target_angle
  logic                  s_axis_tuser;   // new_move
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [PowerW-1:0]     m_axis_tdata;   // drive_power
  logic                  m_axis_tuser;   // done_res
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]   cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned finished;
  int unsigned ticks_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;

  always #6 clk_i = ~clk_i;

  pid_position_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pid_position_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .finished_o    (finished)
  );

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // sink side with random stall bursts
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (idle_on) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  end

  task automatic send_tick(input logic [AngleW-1:0] meas, input logic [AngleW-1:0] targ,
                           input logic nm);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {targ, meas};
    s_axis_tuser  <= nm;
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
  endtask

  // hold the source until every predicted command has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [CfgDataW-1:0] kp, input logic [CfgDataW-1:0] ki,
                                input logic [CfgDataW-1:0] kd, input logic [CfgDataW-1:0] mp,
                                input logic [CfgDataW-1:0] tol, input logic [CfgDataW-1:0] lim);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegKpGain;
    cfg_data_i  <= kp;
    @(posedge clk_i);
    cfg_index_i <= RegKiGain;
    cfg_data_i  <= ki;
    @(posedge clk_i);
    cfg_index_i <= RegKdGain;
    cfg_data_i  <= kd;
    @(posedge clk_i);
    cfg_index_i <= RegMaxPower;
    cfg_data_i  <= mp;
    @(posedge clk_i);
    cfg_index_i <= RegTol;
    cfg_data_i  <= tol;
    @(posedge clk_i);
    cfg_index_i <= RegIntegLim;
    cfg_data_i  <= lim;
    @(posedge clk_i);
    // a write past the list must leave every register alone
    cfg_index_i <= $urandom_range(0, 1) ? RegSpareLo : RegSpareHi;
    cfg_data_i  <= CfgDataW'($urandom_range(0, 65535));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // a move: new target, then the angle closing in on it with some jitter
  task automatic run_move(input int unsigned steps);
    int meas;
    int targ;
    targ = $urandom_range(0, 36000);
    meas = $urandom_range(0, 36000);
    send_tick(AngleW'(meas), AngleW'(targ), 1'b1);
    repeat (steps) begin
      meas = meas + (targ - meas) / int'($urandom_range(2, 5)) + int'($urandom_range(0, 6)) - 3;
      if (meas < 0) meas = 0;
      if (meas > 36000) meas = 36000;
      send_tick(AngleW'(meas), AngleW'(targ), 1'b0);
    end
  endtask

  task automatic send_noise();
    send_tick(AngleW'($urandom_range(0, 65535)), AngleW'($urandom_range(0, 65535)),
              1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned phase_end;
    bit          paused;
    logic [CfgDataW-1:0] tol_pick;
    paused = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= RegKpGain;
    cfg_data_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ticks on the reset settings
    send_tick(16'd0, 16'd0, 1'b1);          // zero error finishes at once
    send_tick(16'd36000, 16'd0, 1'b0);      // already finished, stays so
    send_tick(16'd36000, 16'd0, 1'b1);      // largest in-range error, integral clamps
    send_tick(16'd36000, 16'd0, 1'b0);
    send_tick(16'd0, 16'd36000, 1'b0);      // full swing derivative
    send_tick(16'hFFFF, 16'd0, 1'b1);       // angles beyond range
    send_tick(16'd0, 16'hFFFF, 1'b0);
    send_tick(16'd1000, 16'd1004, 1'b1);    // just inside tolerance
    send_tick(16'd1000, 16'd1005, 1'b1);    // exactly at tolerance, still moving
    send_tick(16'd1005, 16'd1000, 1'b0);
    send_tick(16'd1003, 16'd1000, 1'b0);    // finishing step
    send_tick(16'd20000, 16'd100, 1'b0);

    // largest gains and clamps, zero tolerance
    wait_drained();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    send_tick(16'hFFFF, 16'd0, 1'b1);
    send_tick(16'hFFFF, 16'd0, 1'b0);
    send_tick(16'hFFFF, 16'd0, 1'b0);
    send_tick(16'd0, 16'hFFFF, 1'b0);
    send_tick(16'd0, 16'd0, 1'b0);          // zero tolerance never finishes
    send_tick(16'd0, 16'd0, 1'b1);

    // zero gains and clamps, widest tolerance
    wait_drained();
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd36000, 16'd0);
    send_tick(16'd36000, 16'd0, 1'b1);
    send_tick(16'd35999, 16'd0, 1'b0);
    send_tick(16'd0, 16'd36000, 1'b1);
    send_tick(16'd100, 16'd200, 1'b0);

    // random phases, each under its own settings
    for (int unsigned p = 0; p < NumPhases; p++) begin
      wait_drained();
      case (p)
        0: apply_settings(KpReset, KiReset, KdReset, CfgDataW'(MaxPwrReset), TolReset,
                          CfgDataW'(LimitReset));
        1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3, 16'hFFFF);
        2: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        default: begin
          tol_pick = CfgDataW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 60));
          apply_settings(CfgDataW'($urandom_range(0, 65535)),
                         CfgDataW'($urandom_range(0, 65535)),
                         CfgDataW'($urandom_range(0, 65535)),
                         CfgDataW'($urandom_range(0, 65535)),
                         tol_pick, CfgDataW'($urandom_range(0, 65535)));
        end
      endcase
      // the final phase runs without stalls
      idle_on   = (p == NumPhases - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      phase_end = ticks_sent + PhaseTicks;
      while (ticks_sent < phase_end) begin
        if (p == 3 && !paused && ticks_sent + PhaseTicks / 2 >= phase_end) begin
          wait_drained();
          paused = 1'b1;
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: run_move($urandom_range(5, 40));
          7, 8: repeat ($urandom_range(1, 6)) send_noise();
          default: begin
            // a move broken off by stray ticks
            run_move($urandom_range(1, 4));
            send_noise();
          end
        endcase
      end
    end

    wait_drained();
    repeat (Latency * 2) @(posedge clk_i);
    $display("covered %0d ticks over %0d random setting phases, %0d commands checked",
             ticks_sent, NumPhases, checked);
    $display("%0d commands reported a finished move", finished);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
